/* hdl/signed_int_to_decimal_chars_macros.svh */
// assertion macros shared by the signed integer to decimal text block
`ifndef SIGNED_INT_TO_DECIMAL_CHARS_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_CHARS_MACROS_SVH
`ifndef SYNTHESIS
// checked only while out of reset
`define SITDC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sitdc assertion failed");
// checked at every edge, reset included
`define SITDC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("sitdc assertion failed");
`else
`define SITDC_ASSERT(label, prop)
`define SITDC_ASSERT_ALWAYS(label, prop)
`endif
`endif

/* hdl/sitdc_pkg.sv */
// types and constants of the signed integer to decimal text block
package sitdc_pkg;

  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned NUM_CELLS = 20;
  localparam int unsigned IDX_W     = $clog2(NUM_CELLS);
  localparam int unsigned BITCNT_W  = $clog2(VALUE_W + 1);
  localparam int unsigned CHAR_W    = 8;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [MODE_W-1:0] {
    MODE_INT32 = 3'd0,
    MODE_INT16 = 3'd1,
    MODE_INT8  = 3'd2,
    MODE_INT64 = 3'd3
  } size_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_EMIT
  } state_e;

  // control for the digit chain
  typedef struct packed {
    logic clear;    // zero all digits
    logic shift;    // one double-dabble step
    logic ser_bit;  // next magnitude bit, msb first
  } chain_ctrl_t;

endpackage

/* hdl/sitdc_cell.sv */
// one bcd digit cell of the double-dabble chain
module sitdc_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sitdc_pkg::chain_ctrl_t             ctrl_i,
  input  logic                               bit_i,
  output logic                               bit_o,
  output logic [sitdc_pkg::DIGIT_W-1:0]      digit_o
);

  logic [sitdc_pkg::DIGIT_W-1:0] digit_q;
  logic [sitdc_pkg::DIGIT_W-1:0] digit_d;
  logic [sitdc_pkg::DIGIT_W-1:0] adj;

  // add three when five or more, so the shift carries into the next digit
  assign adj   = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  assign bit_o = adj[sitdc_pkg::DIGIT_W-1];

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = {adj[sitdc_pkg::DIGIT_W-2:0], bit_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

/* hdl/sitdc_chain.sv */
// row of bcd digit cells with leading digit detect and digit read port
module sitdc_chain (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sitdc_pkg::chain_ctrl_t             ctrl_i,
  input  logic [sitdc_pkg::IDX_W-1:0]        rd_idx_i,
  output logic [sitdc_pkg::DIGIT_W-1:0]      rd_digit_o,
  output logic [sitdc_pkg::IDX_W-1:0]        lead_idx_o
);

  logic [sitdc_pkg::NUM_CELLS-1:0] carry;
  logic [sitdc_pkg::DIGIT_W-1:0]   digit [sitdc_pkg::NUM_CELLS];

  assign carry[0] = ctrl_i.ser_bit;

  for (genvar i = 0; i < sitdc_pkg::NUM_CELLS; i++) begin : g_cell
    if (i < sitdc_pkg::NUM_CELLS - 1) begin : g_mid
      sitdc_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl_i),
        .bit_i   (carry[i]),
        .bit_o   (carry[i+1]),
        .digit_o (digit[i])
      );
    end else begin : g_top
      // the top cell never overflows for a 64-bit magnitude
      sitdc_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl_i),
        .bit_i   (carry[i]),
        .bit_o   (),
        .digit_o (digit[i])
      );
    end
  end

  // highest nonzero digit, zero when the whole number is zero
  always_comb begin
    lead_idx_o = '0;
    for (int i = 0; i < sitdc_pkg::NUM_CELLS; i++) begin
      if (digit[i] != '0) begin
        lead_idx_o = sitdc_pkg::IDX_W'(i);
      end
    end
  end

  assign rd_digit_o = digit[rd_idx_i];

endmodule

/* hdl/signed_int_to_decimal_chars.sv */
// signed integer to decimal ascii text, one character per output transaction
// the magnitude of each accepted input goes into the digit chain one bit per cycle,
// width being 32, 16, 8 or 64 bits by size mode (8 for unknown modes); a count state
// follows, then one character per cycle while the output is not stalled. a new input
// is taken after the last character. zero with zero precision: one empty result.
// reset: asynchronous active low, returns to idle with the output empty
`include "signed_int_to_decimal_chars_macros.svh"

module signed_int_to_decimal_chars #(
  parameter int unsigned MAX_CHARS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // value[63:0], precision_given, precision_is_zero
  input  logic [2:0]  s_axis_tuser,  // size_mode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_char[7:0]
  output logic        m_axis_tlast,  // last_char
  output logic [1:0]  m_axis_tuser   // empty_text, zero_pad_cleared
);

  localparam int unsigned KW    = $clog2(MAX_CHARS + 1);
  localparam int unsigned TOT_W = $clog2(sitdc_pkg::NUM_CELLS + 2);
  localparam int unsigned VW    = sitdc_pkg::VALUE_W;

  sitdc_pkg::state_e state_q, state_d;

  logic [VW-1:0]                   sh_q, sh_d;
  logic [sitdc_pkg::BITCNT_W-1:0]  bits_q, bits_d;
  logic                            neg_q, neg_d;
  logic                            zclr_q, zclr_d;
  logic                            empty_q, empty_d;
  logic                            sign_pend_q, sign_pend_d;
  logic [sitdc_pkg::IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic [KW-1:0]                   k_q, k_d;
  logic [KW-1:0]                   emit_q, emit_d;

  logic                            m_valid_q, m_valid_d;
  logic [sitdc_pkg::CHAR_W-1:0]    m_char_q, m_char_d;
  logic                            m_last_q, m_last_d;
  logic                            m_empty_q, m_empty_d;
  logic                            m_zclr_q, m_zclr_d;

  logic                            in_fire;
  logic                            load_out;
  sitdc_pkg::chain_ctrl_t          chain_ctrl;
  logic [sitdc_pkg::DIGIT_W-1:0]   rd_digit;
  logic [sitdc_pkg::IDX_W-1:0]     lead_idx;

  // input decode
  logic [VW-1:0]                   in_value;
  logic                            in_pgiven;
  logic                            in_pzero;
  logic [VW-1:0]                   sel_v;
  logic [VW-1:0]                   mag;
  logic [VW-1:0]                   aligned;
  logic [sitdc_pkg::BITCNT_W-1:0]  width;
  logic                            sel_zero;
  logic                            sel_neg;
  logic                            special;

  // emission helpers
  logic [TOT_W-1:0]                total;
  logic                            is_last;

  assign in_value  = s_axis_tdata[VW-1:0];
  assign in_pgiven = s_axis_tdata[VW];
  assign in_pzero  = s_axis_tdata[VW+1];

  always_comb begin
    case (sitdc_pkg::size_mode_e'(s_axis_tuser))
      sitdc_pkg::MODE_INT32: begin
        sel_v = {{32{in_value[31]}}, in_value[31:0]};
        width = sitdc_pkg::BITCNT_W'(32);
      end
      sitdc_pkg::MODE_INT16: begin
        sel_v = {{48{in_value[15]}}, in_value[15:0]};
        width = sitdc_pkg::BITCNT_W'(16);
      end
      sitdc_pkg::MODE_INT8: begin
        sel_v = {{56{in_value[7]}}, in_value[7:0]};
        width = sitdc_pkg::BITCNT_W'(8);
      end
      sitdc_pkg::MODE_INT64: begin
        sel_v = in_value;
        width = sitdc_pkg::BITCNT_W'(64);
      end
      default: begin
        sel_v = '0;
        width = sitdc_pkg::BITCNT_W'(8);
      end
    endcase
  end

  assign sel_zero = (sel_v == '0);
  assign sel_neg  = sel_v[VW-1];
  // the most negative value negates to 2^63, which fits unsigned
  assign mag      = sel_neg ? (~sel_v + VW'(1)) : sel_v;
  assign special  = sel_zero && in_pgiven && in_pzero;

  // magnitude aligned so its top bit of the selected width goes first
  always_comb begin
    case (width)
      sitdc_pkg::BITCNT_W'(32): aligned = {mag[31:0], 32'd0};
      sitdc_pkg::BITCNT_W'(16): aligned = {mag[15:0], 48'd0};
      sitdc_pkg::BITCNT_W'(64): aligned = mag;
      default:                  aligned = {mag[7:0], 56'd0};
    endcase
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  sitdc_chain u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (chain_ctrl),
    .rd_idx_i   (rd_idx_q),
    .rd_digit_o (rd_digit),
    .lead_idx_o (lead_idx)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sitdc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = special ? sitdc_pkg::ST_EMIT : sitdc_pkg::ST_CONV;
        end
      end
      sitdc_pkg::ST_CONV: begin
        if (bits_q == sitdc_pkg::BITCNT_W'(1)) begin
          state_d = sitdc_pkg::ST_COUNT;
        end
      end
      sitdc_pkg::ST_COUNT: begin
        state_d = sitdc_pkg::ST_EMIT;
      end
      sitdc_pkg::ST_EMIT: begin
        if (load_out && is_last) begin
          state_d = sitdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sitdc_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready      = 1'b0;
    load_out           = 1'b0;
    chain_ctrl.clear   = 1'b0;
    chain_ctrl.shift   = 1'b0;
    chain_ctrl.ser_bit = sh_q[VW-1];
    case (state_q)
      sitdc_pkg::ST_IDLE: begin
        s_axis_tready    = 1'b1;
        chain_ctrl.clear = in_fire;
      end
      sitdc_pkg::ST_CONV: begin
        chain_ctrl.shift = 1'b1;
      end
      sitdc_pkg::ST_COUNT: begin
      end
      sitdc_pkg::ST_EMIT: begin
        load_out = !m_valid_q || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  assign total   = TOT_W'(lead_idx) + TOT_W'(1) + TOT_W'(neg_q);
  assign is_last = (k_q == (emit_q - KW'(1)));

  // datapath
  always_comb begin
    sh_d        = sh_q;
    bits_d      = bits_q;
    neg_d       = neg_q;
    zclr_d      = zclr_q;
    empty_d     = empty_q;
    sign_pend_d = sign_pend_q;
    rd_idx_d    = rd_idx_q;
    k_d         = k_q;
    emit_d      = emit_q;
    m_char_d    = m_char_q;
    m_last_d    = m_last_q;
    m_empty_d   = m_empty_q;
    m_zclr_d    = m_zclr_q;
    m_valid_d   = m_valid_q && !m_axis_tready;

    if (in_fire) begin
      sh_d        = aligned;
      bits_d      = width;
      neg_d       = special ? 1'b0 : sel_neg;
      zclr_d      = sel_zero && in_pgiven;
      empty_d     = special;
      sign_pend_d = 1'b0;
      k_d         = '0;
      emit_d      = KW'(1);
    end

    if (chain_ctrl.shift) begin
      sh_d   = {sh_q[VW-2:0], 1'b0};
      bits_d = bits_q - sitdc_pkg::BITCNT_W'(1);
    end

    if (state_q == sitdc_pkg::ST_COUNT) begin
      rd_idx_d    = lead_idx;
      sign_pend_d = neg_q;
      k_d         = '0;
      emit_d      = (total >= TOT_W'(MAX_CHARS)) ? KW'(MAX_CHARS) : KW'(total);
    end

    if (load_out) begin
      m_valid_d = 1'b1;
      m_last_d  = is_last;
      m_empty_d = empty_q;
      m_zclr_d  = zclr_q;
      k_d       = k_q + KW'(1);
      if (empty_q) begin
        m_char_d = '0;
      end else if (sign_pend_q) begin
        m_char_d    = sitdc_pkg::CHAR_MINUS;
        sign_pend_d = 1'b0;
      end else begin
        m_char_d = sitdc_pkg::CHAR_ZERO + sitdc_pkg::CHAR_W'(rd_digit);
        rd_idx_d = rd_idx_q - sitdc_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sitdc_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q        <= sh_d;
    bits_q      <= bits_d;
    neg_q       <= neg_d;
    zclr_q      <= zclr_d;
    empty_q     <= empty_d;
    sign_pend_q <= sign_pend_d;
    rd_idx_q    <= rd_idx_d;
    k_q         <= k_d;
    emit_q      <= emit_d;
    m_char_q    <= m_char_d;
    m_last_q    <= m_last_d;
    m_empty_q   <= m_empty_d;
    m_zclr_q    <= m_zclr_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_char_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = {m_zclr_q, m_empty_q};

  // one conversion at a time
  `SITDC_ASSERT(a_busy_after_accept, in_fire |=> !s_axis_tready)
  // the final character always returns the control to idle
  `SITDC_ASSERT(a_last_ends_item, (load_out && is_last) |=> state_q == sitdc_pkg::ST_IDLE)
  // never emit more characters than counted
  `SITDC_ASSERT(a_emit_in_range, state_q == sitdc_pkg::ST_EMIT |-> k_q < emit_q)
  // an empty result is the only and last transaction and flags cleared padding
  `SITDC_ASSERT(a_empty_is_last, !(m_valid_q && m_empty_q) || (m_last_q && m_zclr_q))

endmodule

/* bench/testbench.sv */
// testbench for signed_int_to_decimal_chars: directed table and random items checked per character
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MAX_CHARS = 20;
  localparam logic [2:0] MODE_UNKNOWN = 3'd4;
  localparam logic [2:0] MODE_TOP = 3'd7;
  localparam int unsigned NUM_RANDOM = 250;
  localparam int unsigned NUM_DIRECTED = 24;

  typedef struct packed {
    logic [sitdc_pkg::CHAR_W-1:0] ch;
    logic                         last;
    logic                         empty;
    logic                         zclr;
  } text_char_t;

  typedef struct {
    logic [63:0] value;
    logic [2:0]  mode;
    bit          pg;
    bit          pz;
    bit          typed;
    string       text;
    bit          zclr;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // value[63:0], precision_given, precision_is_zero
  logic [2:0]  s_axis_tuser = '0;  // size_mode[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // out_char[7:0]
  logic        m_axis_tlast;  // last_char
  logic [1:0]  m_axis_tuser;  // empty_text, zero_pad_cleared

  text_char_t pending_chars[$];
  int         fail_count = 0;
  bit         calm = 1'b0;
  int         stall_left = 0;

  signed_int_to_decimal_chars i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // expected characters of one conversion, most significant first
  function automatic void format_decimal(logic [63:0] raw, logic [2:0] mode, bit pg, bit pz);
    logic [63:0] v;
    logic [63:0] mag;
    logic [sitdc_pkg::DIGIT_W-1:0] digits [sitdc_pkg::NUM_CELLS];
    int n;
    int total;
    int emit;
    int k;
    bit neg;
    bit zclr;
    case (mode)
      sitdc_pkg::MODE_INT32: v = {{32{raw[31]}}, raw[31:0]};
      sitdc_pkg::MODE_INT16: v = {{48{raw[15]}}, raw[15:0]};
      sitdc_pkg::MODE_INT8:  v = {{56{raw[7]}}, raw[7:0]};
      sitdc_pkg::MODE_INT64: v = raw;
      default:               v = '0;
    endcase
    zclr = (v == 64'd0) && pg;
    if (zclr && pz) begin
      pending_chars.push_back('{8'h00, 1'b1, 1'b1, 1'b1});
      return;
    end
    neg = v[63];
    mag = neg ? -v : v;
    n = 0;
    do begin
      digits[n] = sitdc_pkg::DIGIT_W'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 64'd0 && n < sitdc_pkg::NUM_CELLS);
    total = n + int'(neg);
    emit = (total < MAX_CHARS) ? total : MAX_CHARS;
    k = 0;
    if (neg && k < emit) begin
      pending_chars.push_back('{sitdc_pkg::CHAR_MINUS, k == emit - 1, 1'b0, zclr});
      k++;
    end
    for (int i = n - 1; i >= 0 && k < emit; i--) begin
      pending_chars.push_back('{sitdc_pkg::CHAR_ZERO + sitdc_pkg::CHAR_W'(digits[i]),
                                k == emit - 1, 1'b0, zclr});
      k++;
    end
  endfunction

  // typed expectation; an empty string stands for the empty-text result
  function automatic void push_text(string s, bit zclr);
    if (s.len() == 0) begin
      pending_chars.push_back('{8'h00, 1'b1, 1'b1, zclr});
    end else begin
      for (int i = 0; i < s.len(); i++)
        pending_chars.push_back('{s[i], i == s.len() - 1, 1'b0, zclr});
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (calm) return 0;
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [63:0] rand_value(logic [2:0] mode);
    logic [63:0] r;
    logic [63:0] p;
    int w;
    bit b;
    r = {$urandom, $urandom};
    case (mode)
      sitdc_pkg::MODE_INT32: w = 32;
      sitdc_pkg::MODE_INT16: w = 16;
      sitdc_pkg::MODE_INT64: w = 64;
      default:               w = 8;
    endcase
    b = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: begin
        // zero in the used bits, junk above
        for (int i = 0; i < w; i++) r[i] = 1'b0;
      end
      1: begin
        p = 64'($urandom_range(0, 20));
        r = b ? -p : p;
      end
      2: begin
        p = 64'd1;
        repeat ($urandom_range(0, 18)) p = p * 10;
        p = p + 64'($urandom_range(0, 2)) - 64'd1;
        r = b ? -p : p;
      end
      3: begin
        // most positive or most negative of the width
        for (int i = 0; i < w - 1; i++) r[i] = !b;
        r[w-1] = b;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(input logic [63:0] value, input logic [2:0] mode, input bit pg,
                           input bit pz, input bit typed, input string text, input bit zclr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata = {6'b0, pz, pg, value};
    s_axis_tuser = mode;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (typed) push_text(text, zclr);
    else format_decimal(value, mode, pg, pz);
    @(negedge clk_i);
  endtask

  task automatic drain_pending();
    while (pending_chars.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver side: random stalls, none while calm
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= rst_ni;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        note_failure($sformatf("unexpected character: char=%h last=%b user=%b",
                               m_axis_tdata, m_axis_tlast, m_axis_tuser));
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata !== want.ch || m_axis_tlast !== want.last ||
            m_axis_tuser !== {want.zclr, want.empty})
          note_failure($sformatf(
            "mismatch: expected char=%h last=%b empty=%b zclr=%b, got char=%h last=%b user=%b",
            want.ch, want.last, want.empty, want.zclr,
            m_axis_tdata, m_axis_tlast, m_axis_tuser));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    stim_row_t  directed_rows [NUM_DIRECTED];
    logic [2:0] mode;
    stim_row_t  row;

    directed_rows = '{
      '{64'd0, sitdc_pkg::MODE_INT32, 1'b0, 1'b0, 1'b1, "0", 1'b0},
      '{64'd0, sitdc_pkg::MODE_INT32, 1'b1, 1'b1, 1'b1, "", 1'b1},
      '{64'd0, sitdc_pkg::MODE_INT32, 1'b1, 1'b0, 1'b1, "0", 1'b1},
      '{64'd0, sitdc_pkg::MODE_INT32, 1'b0, 1'b1, 1'b1, "0", 1'b0},
      '{64'h7fff_ffff_ffff_ffff, sitdc_pkg::MODE_INT64, 1'b1, 1'b1, 1'b1,
        "9223372036854775807", 1'b0},
      '{64'h8000_0000_0000_0000, sitdc_pkg::MODE_INT64, 1'b0, 1'b0, 1'b1,
        "-9223372036854775808", 1'b0},
      '{64'hffff_ffff_ffff_ffff, sitdc_pkg::MODE_INT64, 1'b1, 1'b0, 1'b1, "-1", 1'b0},
      '{64'hdead_beef_7fff_ffff, sitdc_pkg::MODE_INT32, 1'b0, 1'b0, 1'b1,
        "2147483647", 1'b0},
      '{64'h0123_4567_8000_0000, sitdc_pkg::MODE_INT32, 1'b1, 1'b1, 1'b1,
        "-2147483648", 1'b0},
      '{64'hffff_ffff_ffff_7fff, sitdc_pkg::MODE_INT16, 1'b0, 1'b0, 1'b1, "32767", 1'b0},
      '{64'h0000_0000_0000_8000, sitdc_pkg::MODE_INT16, 1'b0, 1'b1, 1'b1, "-32768", 1'b0},
      '{64'h5a5a_5a5a_5a5a_5a7f, sitdc_pkg::MODE_INT8, 1'b0, 1'b0, 1'b1, "127", 1'b0},
      '{64'h0000_0000_0000_0080, sitdc_pkg::MODE_INT8, 1'b0, 1'b0, 1'b1, "-128", 1'b0},
      '{64'h0000_0000_0000_00ff, sitdc_pkg::MODE_INT8, 1'b1, 1'b0, 1'b1, "-1", 1'b0},
      '{64'hffff_ffff_ffff_ff00, sitdc_pkg::MODE_INT8, 1'b1, 1'b1, 1'b1, "", 1'b1},
      '{64'hffff_ffff_ffff_ffff, MODE_UNKNOWN, 1'b0, 1'b0, 1'b1, "0", 1'b0},
      '{64'hffff_ffff_ffff_ffff, MODE_UNKNOWN, 1'b1, 1'b1, 1'b1, "", 1'b1},
      '{64'h1234_5678_9abc_def0, 3'd5, 1'b1, 1'b0, 1'b1, "0", 1'b1},
      '{64'h0000_0000_0000_0001, 3'd6, 1'b0, 1'b1, 1'b1, "0", 1'b0},
      '{64'h8000_0000_0000_0001, MODE_TOP, 1'b1, 1'b1, 1'b1, "", 1'b1},
      '{64'haaaa_aaaa_aaaa_aaaa, sitdc_pkg::MODE_INT64, 1'b0, 1'b0, 1'b0, "", 1'b0},
      '{64'h5555_5555_5555_5555, sitdc_pkg::MODE_INT64, 1'b1, 1'b1, 1'b0, "", 1'b0},
      '{64'h0000_0000_0000_3039, sitdc_pkg::MODE_INT32, 1'b1, 1'b0, 1'b0, "", 1'b0},
      '{64'h0000_0000_0de0_b6b3, sitdc_pkg::MODE_INT32, 1'b0, 1'b1, 1'b0, "", 1'b0}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_item(row.value, row.mode, row.pg, row.pz, row.typed, row.text, row.zclr);
    end
    s_axis_tvalid = 1'b0;
    drain_pending();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      // sender holds off until the block has fully drained
      if (n == NUM_RANDOM / 2) begin
        s_axis_tvalid = 1'b0;
        drain_pending();
      end
      mode = ($urandom_range(0, 9) < 9)
             ? 3'($urandom_range(sitdc_pkg::MODE_INT32, sitdc_pkg::MODE_INT64))
             : 3'($urandom_range(MODE_UNKNOWN, MODE_TOP));
      send_item(rand_value(mode), mode, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'b0, "", 1'b0);
    end
    s_axis_tvalid = 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (pending_chars.size() != 0)
      note_failure($sformatf("%0d expected characters never arrived", pending_chars.size()));
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
